[src/fcds_pkg.sv]
// ----------------------------------------------------------------------------
// Fractional clock divider search package
// Shared payload types, status codes and sizing constants.
// ----------------------------------------------------------------------------
package fcds_pkg;

  localparam int unsigned DividerLimitDef = 4096;
  localparam int unsigned NWidthDef       = 24;

  localparam int unsigned StatusW  = 3;
  localparam int unsigned DividerW = 13;
  localparam int unsigned MnW      = 24;

  // Result status codes.
  localparam logic [StatusW-1:0] StDivOnly  = 3'd0;
  localparam logic [StatusW-1:0] StMnUsed   = 3'd1;
  localparam logic [StatusW-1:0] StRatioLow = 3'd2;
  localparam logic [StatusW-1:0] StNWide    = 3'd3;
  localparam logic [StatusW-1:0] StNoDiv    = 3'd4;

  typedef struct packed {
    logic [31:0] source_freq;
    logic [31:0] bit_clock;
  } fcds_in_t;

  typedef struct packed {
    logic [StatusW-1:0]  status;
    logic [DividerW-1:0] divider;
    logic [MnW-1:0]      m_value;
    logic [MnW-1:0]      n_value;
  } fcds_out_t;

endpackage

[src/fcds_divu.sv]
// ----------------------------------------------------------------------------
// Fractional clock divider search: shared divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fcds_divu import fcds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quot_o,
  output logic [31:0] rem_o
);

  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [31:0] quot_q, quot_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [32:0] trial;

  // One restoring step: shift in the next numerator bit and try to subtract.
  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q[31:0], quot_q[31]} - {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d  = trial;
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d  = {rem_q[31:0], quot_q[31]};
        quot_d = {quot_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q[31:0];

endmodule

[src/fractional_clock_divider_search.sv]
// ----------------------------------------------------------------------------
// Fractional clock divider search
// Finds an integer divider and reduced M/N fraction for a bit clock.
// ----------------------------------------------------------------------------
//   Channel | Signals                 | Beat
//   input   | in_valid_i / in_ready_o | source_freq, bit_clock
//   output  | out_valid_o/out_ready_i | status, divider, m_value, n_value
//
// Every arithmetic step runs through one shared serial divider; a division is
// a start state, the restoring steps and a wait state that takes the result.
// A beat with a nonzero bit clock uses one division for the first tests and,
// when it searches, one per divisor tried in the even search (up to
// DIVIDER_LIMIT/2), one for the quotient, one per Euclid step and two for M
// and N, plus the accept state and a state per search or Euclid exit. Reset
// clears the sequencer; the block is ready once idle.
// A stalled result holds in the output register and blocks the next beat.
module fractional_clock_divider_search import fcds_pkg::*; #(
  parameter int unsigned DIVIDER_LIMIT = DividerLimitDef,
  parameter int unsigned N_WIDTH       = NWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  fcds_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output fcds_out_t out_data_o
);

  localparam logic [32:0] Limit = 33'(DIVIDER_LIMIT);
  localparam logic [32:0] NMax  = 33'((64'd1 << N_WIDTH) - 64'd1);

  typedef enum logic [3:0] {
    S_IDLE, S_QDIV, S_QWAIT, S_SRCH, S_SWAIT, S_FDIV, S_FWAIT,
    S_GCD, S_GWAIT, S_MDIV, S_MWAIT, S_NDIV, S_NWAIT, S_OUT
  } state_e;

  state_e      state_q;
  logic [31:0] freq_q, bclk_q;
  logic [32:0] div_q;
  logic [31:0] a_q, b_q, m_q;
  fcds_out_t   res_q;

  logic        du_start, du_done;
  logic [31:0] du_num, du_den, du_quot, du_rem;

  fcds_divu u_divu (
    .clk_i, .rst_ni, .start_i(du_start), .num_i(du_num), .den_i(du_den),
    .done_o(du_done), .quot_o(du_quot), .rem_o(du_rem)
  );

  // Divider operands chosen by the sequencer state.
  always_comb begin
    du_start = 1'b0;
    du_num   = freq_q;
    du_den   = bclk_q;
    unique case (state_q)
      S_QDIV: du_start = 1'b1;
      S_SRCH: begin du_start = 1'b1; du_den = div_q[31:0]; end
      S_FDIV: begin du_start = 1'b1; du_den = div_q[31:0]; end
      S_GCD:  begin du_start = 1'b1; du_num = a_q; du_den = b_q; end
      S_MDIV: begin du_start = 1'b1; du_num = bclk_q; du_den = a_q; end
      S_NDIV: begin du_start = 1'b1; du_num = m_q; du_den = a_q; end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = res_q;

  // Sequencer with the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      freq_q  <= '0;
      bclk_q  <= '0;
      div_q   <= '0;
      a_q     <= '0;
      b_q     <= '0;
      m_q     <= '0;
      res_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            freq_q <= in_data_i.source_freq;
            bclk_q <= in_data_i.bit_clock;
            if (in_data_i.bit_clock == '0) begin
              res_q   <= '{StNoDiv, '0, '0, '0};
              state_q <= S_OUT;
            end else begin
              state_q <= S_QDIV;
            end
          end
        end
        S_QDIV: state_q <= S_QWAIT;
        S_QWAIT: begin
          if (du_done) begin
            if (du_rem == '0 && {1'b0, du_quot} < Limit) begin
              res_q   <= '{StDivOnly, DividerW'(du_quot), MnW'(1), MnW'(1)};
              state_q <= S_OUT;
            end else if ({bclk_q, 1'b0} >= {1'b0, freq_q}) begin
              res_q   <= '{StRatioLow, '0, '0, '0};
              state_q <= S_OUT;
            end else begin
              // Make even (quotient is at least two here), then clamp.
              if ({1'b0, du_quot[31:1], 1'b0} > Limit) div_q <= Limit;
              else div_q <= {1'b0, du_quot[31:1], 1'b0};
              state_q <= S_SRCH;
            end
          end
        end
        S_SRCH: begin
          if (div_q <= 33'd1) begin
            if (div_q == '0) begin
              res_q   <= '{StNoDiv, '0, '0, '0};
              state_q <= S_OUT;
            end else begin
              state_q <= S_FDIV;
            end
          end else begin
            state_q <= S_SWAIT;
          end
        end
        S_SWAIT: begin
          if (du_done) begin
            if (du_rem == '0) state_q <= S_FDIV;
            else begin
              div_q   <= div_q - 33'd2;
              state_q <= S_SRCH;
            end
          end
        end
        S_FDIV: state_q <= S_FWAIT;
        S_FWAIT: begin
          if (du_done) begin
            m_q     <= du_quot;
            a_q     <= bclk_q;
            b_q     <= du_quot;
            state_q <= S_GCD;
          end
        end
        S_GCD: begin
          if (b_q == '0) begin
            if (a_q == '0) begin
              res_q   <= '{StNoDiv, '0, '0, '0};
              state_q <= S_OUT;
            end else begin
              state_q <= S_MDIV;
            end
          end else begin
            state_q <= S_GWAIT;
          end
        end
        S_GWAIT: begin
          if (du_done) begin
            a_q     <= b_q;
            b_q     <= du_rem;
            state_q <= S_GCD;
          end
        end
        S_MDIV: state_q <= S_MWAIT;
        S_MWAIT: begin
          if (du_done) begin
            res_q.m_value <= MnW'(du_quot);
            state_q       <= S_NDIV;
          end
        end
        S_NDIV: state_q <= S_NWAIT;
        S_NWAIT: begin
          if (du_done) begin
            if ({1'b0, du_quot} > NMax) begin
              res_q <= '{StNWide, '0, '0, '0};
            end else begin
              res_q.status  <= StMnUsed;
              res_q.divider <= DividerW'(div_q);
              res_q.n_value <= MnW'(du_quot);
            end
            state_q <= S_OUT;
          end
        end
        S_OUT: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[verif/tb_fractional_clock_divider_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractional clock divider search testbench
// Drives source/bit clock pairs with random gaps and receiver stalls, predicts
// each divider and M/N result and checks every output beat in order.
// ----------------------------------------------------------------------------
module tb_fractional_clock_divider_search;
  import fcds_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  fcds_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  fcds_out_t out_data_o;

  fcds_out_t expected_results[$];
  int unsigned mismatch_count = 0;
  bit          hold_request = 1'b0;
  bit          holding = 1'b0;

  fractional_clock_divider_search u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Euclid on 32-bit values.
  function automatic logic [31:0] common_divisor(logic [31:0] a, logic [31:0] b);
    logic [31:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Works out the divider, status and reduced fraction for one request.
  function automatic fcds_out_t predict_divider(fcds_in_t req);
    fcds_out_t       res;
    longint unsigned freq;
    longint unsigned bclk;
    longint unsigned div;
    logic [31:0]     quot;
    logic [31:0]     g;
    longint unsigned m;
    longint unsigned n;
    res  = '0;
    freq = 64'(req.source_freq);
    bclk = 64'(req.bit_clock);
    if (bclk == 0) begin
      res.status = StNoDiv;
      return res;
    end
    div = freq / bclk;
    if (freq % bclk == 0 && div < DividerLimitDef) begin
      res.status  = StDivOnly;
      res.divider = div[DividerW-1:0];
      res.m_value = MnW'(1);
      res.n_value = MnW'(1);
      return res;
    end
    if (bclk * 2 >= freq) begin
      res.status = StRatioLow;
      return res;
    end
    if (div > 1 && div[0]) div--;
    if (div > DividerLimitDef) div = 64'(DividerLimitDef);
    while (div > 1 && (freq % div) != 0) div -= 2;
    if (div == 0) begin
      res.status = StNoDiv;
      return res;
    end
    quot = 32'(freq / div);
    g = common_divisor(req.bit_clock, quot);
    if (g == 0) begin
      res.status = StNoDiv;
      return res;
    end
    m = 64'(req.bit_clock / g);
    n = 64'(quot / g);
    if (n > ((64'd1 << NWidthDef) - 1)) begin
      res.status = StNWide;
      return res;
    end
    res.status  = StMnUsed;
    res.divider = div[DividerW-1:0];
    res.m_value = m[MnW-1:0];
    res.n_value = n[MnW-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_cycles();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one beat and waits until it is taken.
  task automatic send_request(logic [31:0] freq, logic [31:0] bclk);
    int unsigned gap;
    gap = gap_cycles();
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i.source_freq = freq;
    in_data_i.bit_clock   = bclk;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  // Well-formed search case: the quotient lands just above an even divider
  // that divides the source, so the search stops at once.
  task automatic send_search_case();
    longint unsigned d;
    longint unsigned k;
    longint unsigned r;
    d = 64'(2 * $urandom_range(1, 2048));
    if ($urandom_range(0, 3) == 0) d = 64'(2 * $urandom_range(1, 16));
    k = 64'($urandom_range(32'(d + 2), 32'(32'hFFFF_FFFF / d)));
    r = 64'($urandom_range(1, 32'(k / (d + 1))));
    send_request(32'(d * k), 32'(k - r));
  endtask

  // Receiver: random stalls, or a long hold when one is requested.
  always @(negedge clk_i) begin
    if (holding) out_ready_i <= 1'b0;
    else if ($urandom_range(0, 9) < 7) out_ready_i <= 1'b1;
    else out_ready_i <= 1'b0;
  end

  // Long receiver hold, counted in cycles.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        holding = 1'b1;
        repeat (400) @(negedge clk_i);
        holding = 1'b0;
        hold_request = 1'b0;
      end
    end
  end

  // Records each accepted request and checks each result beat.
  always @(posedge clk_i) begin
    fcds_out_t want;
    if (rst_ni && in_valid_i && in_ready_o) expected_results.push_back(predict_divider(in_data_i));
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", out_data_o, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.status != want.status)
          report_mismatch("status", out_data_o.status, want.status);
        if (out_data_o.divider != want.divider)
          report_mismatch("divider", out_data_o.divider, want.divider);
        if (out_data_o.m_value != want.m_value)
          report_mismatch("m_value", out_data_o.m_value, want.m_value);
        if (out_data_o.n_value != want.n_value)
          report_mismatch("n_value", out_data_o.n_value, want.n_value);
      end
    end
  end

  // Zero inputs, ratio limits and the widest values.
  task automatic test_edge_values();
    send_request(32'd0, 32'd0);
    send_request(32'd5, 32'd0);
    send_request(32'd0, 32'd5);
    send_request(32'd10, 32'd6);
    send_request(32'd10, 32'd5);
    send_request(32'd1, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFE, 32'h7FFF_FFFE);
    send_request(32'h8000_0000, 32'd1);
    send_request(32'hFFFF_FFFF, 32'd1);
    send_request(32'd9, 32'd2);
  endtask

  // Exact quotients below, at and above the divider limit.
  task automatic test_exact_quotient();
    send_request(32'd100, 32'd10);
    send_request(32'd4095 * 32'd7, 32'd7);
    send_request(32'd4096 * 32'd3, 32'd3);
    send_request(32'd8192 * 32'd5, 32'd5);
    send_request(32'd12_288_000, 32'd3_072_000);
  endtask

  // Search path with a reduced fraction, including N too wide.
  task automatic test_fraction_search();
    send_request(32'd48_000_000, 32'd3_072_000);
    send_request(32'd24_576_000, 32'd2_822_400);
    send_request(32'd38_400_000, 32'd1_411_200);
    send_request(32'd2_000_000_006, 32'd3);
    send_request(32'd1_000_003 * 32'd2, 32'd333_334);
  endtask

  // Receiver holds off while requests keep coming.
  task automatic test_output_backpressure();
    hold_request = 1'b1;
    repeat (12) send_search_case();
  endtask

  // Mostly well-formed search cases, the rest unconstrained values.
  task automatic test_random_requests();
    repeat (110) begin
      if ($urandom_range(0, 9) < 7) send_search_case();
      else send_request($urandom(), $urandom() >> $urandom_range(0, 31));
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_edge_values();
    test_exact_quotient();
    test_fraction_search();
    wait_drained();
    test_output_backpressure();
    test_random_requests();
    wait_drained();
    repeat (200) @(negedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS fractional_clock_divider_search");
    end else begin
      $display("FAIL fractional_clock_divider_search");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #(4 * 60_000_000);
    $display("FAIL fractional_clock_divider_search");
    $finish;
  end

endmodule
